[hdl/utf8_to_utf16_transcoder_assert.svh]
// Assertion macros used by the checker file of the UTF-8 to UTF-16 transcoder.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define U8U16_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define U8U16_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/u8u16_pkg.sv]
// Package for the UTF-8 to UTF-16 transcoder: result types and code constants.
// Used by the decoder, the result queue and the top level; depends on nothing.
package u8u16_pkg;

  localparam int unsigned RES_DEPTH_DEF = 4;

  localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
  localparam logic [7:0]  LEAD_LOW      = 8'hC0;
  localparam logic [7:0]  LEAD_HIGH     = 8'hFD;
  localparam logic [7:0]  LEAD2_LIMIT   = 8'hE0;
  localparam logic [7:0]  LEAD3_LIMIT   = 8'hF0;
  localparam logic [7:0]  LEAD4_LIMIT   = 8'hF8;
  localparam logic [1:0]  CONT_TAG      = 2'b10;

  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] BMP_MAX        = 21'h00FFFF;
  localparam logic [20:0] POINT_MAX      = 21'h10FFFF;
  localparam logic [20:0] SUPP_OFFSET    = 21'h010000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_error;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

[hdl/utf8_to_utf16_transcoder.sv]
// A byte accepted at the input waits in the input register until the result queue has
// room, then its results are pushed into the queue, whose head drives the output.
// Throughput: one byte per cycle while each byte gives at most one result and the queue
// has room; two results from one byte take two transfers on the one-result-a-cycle port.
// Reset clears the sequence state, the input register's full flag and the result queue.
// Top level of the UTF-8 to UTF-16 transcoder; depends on u8u16_pkg,
// u8u16_decode and u8u16_queue.
module utf8_to_utf16_transcoder #(
  parameter int unsigned RES_DEPTH = u8u16_pkg::RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        is_error,
  output logic        last_of_run
);
  import u8u16_pkg::*;

  logic         in_full;
  logic [7:0]   byte_q;
  logic         room;
  logic         advance;
  result_pair_t pair;
  result_t      head;

  assign advance  = in_full && room;
  assign in_ready = !in_full || room;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (in_valid && in_ready) || (in_full && !advance);
    end
  end

  u8u16_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .byte_q (byte_q),
    .pair   (pair)
  );

  u8u16_queue #(
    .DEPTH (RES_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .pair      (pair),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign code_unit   = head.code_unit;
  assign is_error    = head.is_error;
  assign last_of_run = head.last_of_run;

endmodule

[hdl/u8u16_decode.sv]
// Decoder of the transcoder: holds the sequence state and turns one byte into
// up to two results. Depends on u8u16_pkg.
module u8u16_decode (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              byte_q,
  output u8u16_pkg::result_pair_t pair
);
  import u8u16_pkg::*;

  typedef struct packed {
    logic       has;
    result_t    res;
    logic [1:0] pend;
    logic [20:0] point;
  } lead_t;

  logic [1:0]  bytes_pending;
  logic [1:0]  bytes_pending_next;
  logic [20:0] partial_point;
  logic [20:0] partial_point_next;
  logic [20:0] shifted;
  logic [1:0]  pend_dec;
  logic [20:0] supp;
  lead_t       lead;

  function automatic lead_t take_lead(input logic [7:0] b);
    lead_t l;
    l = '0;
    if (b < ASCII_LIMIT) begin
      l.has = 1'b1;
      l.res.code_unit = {8'h00, b};
    end else if (b < LEAD_LOW || b > LEAD_HIGH || b >= LEAD4_LIMIT) begin
      l.has = 1'b1;
      l.res.is_error = 1'b1;
    end else if (b < LEAD2_LIMIT) begin
      l.pend = 2'd1;
      l.point = {16'h0000, b[4:0]};
    end else if (b < LEAD3_LIMIT) begin
      l.pend = 2'd2;
      l.point = {17'h00000, b[3:0]};
    end else begin
      l.pend = 2'd3;
      l.point = {18'h00000, b[2:0]};
    end
    return l;
  endfunction

  assign shifted  = {partial_point[14:0], byte_q[5:0]};
  assign pend_dec = bytes_pending - 2'd1;
  assign supp     = shifted - SUPP_OFFSET;
  assign lead     = take_lead(byte_q);

  always_comb begin
    pair = '0;
    bytes_pending_next = bytes_pending;
    partial_point_next = partial_point;
    if (bytes_pending != 2'd0) begin
      if (byte_q[7:6] == CONT_TAG) begin
        bytes_pending_next = pend_dec;
        partial_point_next = shifted;
        if (pend_dec == 2'd0) begin
          partial_point_next = '0;
          if (shifted <= BMP_MAX) begin
            pair.count = 2'd1;
            pair.first.code_unit = shifted[15:0];
          end else if (shifted <= POINT_MAX) begin
            pair.count = 2'd2;
            pair.first.code_unit = HIGH_SURR_BASE + {6'b000000, supp[19:10]};
            pair.second.code_unit = LOW_SURR_BASE + {6'b000000, shifted[9:0]};
          end else begin
            pair.count = 2'd1;
            pair.first.is_error = 1'b1;
          end
        end
      end else begin
        pair.first.is_error = 1'b1;
        bytes_pending_next = lead.pend;
        partial_point_next = lead.point;
        if (lead.has) begin
          pair.count = 2'd2;
          pair.second = lead.res;
        end else begin
          pair.count = 2'd1;
        end
      end
    end else begin
      bytes_pending_next = lead.pend;
      partial_point_next = lead.point;
      if (lead.has) begin
        pair.count = 2'd1;
        pair.first = lead.res;
      end
    end
    if (pair.count == 2'd1) begin
      pair.first.last_of_run = 1'b1;
    end
    if (pair.count == 2'd2) begin
      pair.second.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      partial_point <= '0;
    end else if (step) begin
      bytes_pending <= bytes_pending_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

[hdl/u8u16_queue.sv]
// Result queue of the transcoder: takes up to two results per cycle and hands
// one per transfer to the output channel. Depends on u8u16_pkg.
module u8u16_queue #(
  parameter int unsigned DEPTH = u8u16_pkg::RES_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  u8u16_pkg::result_pair_t pair,
  output logic                    room,
  output logic                    out_valid,
  input  logic                    out_ready,
  output u8u16_pkg::result_t      head
);
  import u8u16_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  result_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [PTR_W-1:0]   wr_ptr_1;
  logic [PTR_W-1:0]   wr_ptr_2;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   rd_ptr_1;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [1:0]         push_n;
  logic               pop;

  assign wr_ptr_1 = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
  assign wr_ptr_2 = (wr_ptr_1 == LAST_PTR) ? '0 : wr_ptr_1 + 1'b1;
  assign rd_ptr_1 = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;

  assign push_n    = push ? pair.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = slots[rd_ptr];
  assign room      = (count <= CNT_W'(DEPTH - 2));

  always_comb begin
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
    case (push_n)
      2'd1:    wr_ptr_next = wr_ptr_1;
      2'd2:    wr_ptr_next = wr_ptr_2;
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wr_ptr] <= pair.first;
    end
    if (push_n == 2'd2) begin
      slots[wr_ptr_1] <= pair.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr_1;
      end
    end
  end

endmodule

[hdl/u8u16_chk.sv]
// Port-level checker for the transcoder and the bind that attaches it.
// Depends on utf8_to_utf16_transcoder_assert.svh.
`include "utf8_to_utf16_transcoder_assert.svh"

module u8u16_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_unit,
  input logic        is_error,
  input logic        last_of_run
);

  `U8U16_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "output valid after reset")

  `U8U16_ASSERT_IMPLY(a_error_zero, clk, rst, out_valid && is_error,
    code_unit == 16'h0000, "error result carries a non-zero unit")

  `U8U16_ASSERT_IMPLY(a_run_tail, clk, rst, out_valid && !last_of_run,
    is_error || code_unit[15:10] == 6'b110110,
    "result before the end of a run is neither an error nor a high surrogate")

  `U8U16_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(code_unit) && $stable(is_error) && $stable(last_of_run),
    "stalled result changed")

  `U8U16_ASSERT_IMPLY(a_stall_full, clk, rst, !in_ready, out_valid,
    "input stalled while no result is waiting")

endmodule

bind utf8_to_utf16_transcoder u8u16_chk u_chk (.*);

[verif/tb_utf8_to_utf16_transcoder.sv]
// Testbench for the UTF-8 to UTF-16 transcoder: a table of opening bytes, then random byte
// streams, with every result transfer checked against the table or a behavioural decoder
// kept in step. Depends on u8u16_pkg and the utf8_to_utf16_transcoder RTL.
module tb_utf8_to_utf16_transcoder;
  import u8u16_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TABLE_ROWS   = 25;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_SINGLE
  } row_kind_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_HALF,
    READY_RARE
  } ready_mode_t;

  typedef struct packed {
    logic [7:0]  value;
    row_kind_t   kind;
    logic [15:0] unit;
    logic        err;
  } opening_row_t;

  opening_row_t opening_bytes [TABLE_ROWS] = '{
    '{8'h00, ROW_SINGLE,  16'h0000, 1'b0},
    '{8'h7F, ROW_SINGLE,  16'h007F, 1'b0},
    '{8'h80, ROW_SINGLE,  16'h0000, 1'b1},
    '{8'hFF, ROW_SINGLE,  16'h0000, 1'b1},
    '{8'hF8, ROW_SINGLE,  16'h0000, 1'b1},
    '{8'hFD, ROW_SINGLE,  16'h0000, 1'b1},
    '{8'hC2, ROW_SILENT,  16'h0000, 1'b0},
    '{8'hA9, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hEF, ROW_SILENT,  16'h0000, 1'b0},
    '{8'hBF, ROW_SILENT,  16'h0000, 1'b0},
    '{8'hBF, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hF4, ROW_SILENT,  16'h0000, 1'b0},
    '{8'h8F, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hBF, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hBF, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hF4, ROW_SILENT,  16'h0000, 1'b0},
    '{8'h90, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'h80, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'h80, ROW_SINGLE,  16'h0000, 1'b1},
    '{8'hC3, ROW_SILENT,  16'h0000, 1'b0},
    '{8'h41, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hE2, ROW_SILENT,  16'h0000, 1'b0},
    '{8'hF0, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hC3, ROW_PREDICT, 16'h0000, 1'b0},
    '{8'hFE, ROW_PREDICT, 16'h0000, 1'b0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        is_error;
  logic        last_of_run;

  result_t     pending_units [$];
  logic [1:0]  seq_left = 2'd0;
  logic [20:0] seq_point = 21'd0;
  int          burst_left = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  utf8_to_utf16_transcoder uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_unit   (code_unit),
    .is_error    (is_error),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_pair_t add_unit(result_pair_t pair, logic [15:0] unit, logic err);
    result_t r;
    r = '{code_unit: unit, is_error: err, last_of_run: 1'b0};
    if (pair.count == 2'd0) begin
      pair.first = r;
    end else begin
      pair.second = r;
    end
    pair.count = pair.count + 2'd1;
    return pair;
  endfunction

  // Advances the decoder by one byte and returns the code units that the byte completes.
  function automatic result_pair_t decode_byte(logic [7:0] b);
    result_pair_t pair;
    logic         as_lead;
    logic [20:0]  offset;
    pair = '0;
    as_lead = 1'b1;
    if (seq_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        as_lead = 1'b0;
        seq_point = {seq_point[14:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          if (seq_point <= 21'h00FFFF) begin
            pair = add_unit(pair, seq_point[15:0], 1'b0);
          end else if (seq_point <= 21'h10FFFF) begin
            offset = seq_point - 21'h010000;
            pair = add_unit(pair, 16'hD800 + {6'd0, offset[19:10]}, 1'b0);
            pair = add_unit(pair, 16'hDC00 + {6'd0, seq_point[9:0]}, 1'b0);
          end else begin
            pair = add_unit(pair, 16'h0000, 1'b1);
          end
          seq_point = 21'd0;
        end
      end else begin
        pair = add_unit(pair, 16'h0000, 1'b1);
        seq_left = 2'd0;
        seq_point = 21'd0;
      end
    end
    if (as_lead) begin
      if (b < 8'h80) begin
        pair = add_unit(pair, {8'h00, b}, 1'b0);
      end else if (b < 8'hC0 || b > 8'hF7) begin
        pair = add_unit(pair, 16'h0000, 1'b1);
      end else if (b < 8'hE0) begin
        seq_left = 2'd1;
        seq_point = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
        seq_left = 2'd2;
        seq_point = {17'd0, b[3:0]};
      end else begin
        seq_left = 2'd3;
        seq_point = {18'd0, b[2:0]};
      end
    end
    if (pair.count == 2'd2) begin
      pair.second.last_of_run = 1'b1;
    end else if (pair.count == 2'd1) begin
      pair.first.last_of_run = 1'b1;
    end
    return pair;
  endfunction

  task automatic send_byte(input logic [7:0] b, input row_kind_t kind, input logic [15:0] unit,
                           input logic err);
    int           gap;
    result_pair_t pair;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    burst_left = burst_left - 1;
    pair = decode_byte(b);
    case (kind)
      ROW_SINGLE: begin
        pending_units.push_back('{code_unit: unit, is_error: err, last_of_run: 1'b1});
      end
      ROW_PREDICT: begin
        if (pair.count >= 2'd1) pending_units.push_back(pair.first);
        if (pair.count == 2'd2) pending_units.push_back(pair.second);
      end
      default: begin
      end
    endcase
  endtask

  initial begin : stimulus
    logic [7:0] seq [4];
    int         seq_len;
    int         pick;
    int         sent;
    int         k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < TABLE_ROWS; k++) begin
      send_byte(opening_bytes[k].value, opening_bytes[k].kind, opening_bytes[k].unit,
                opening_bytes[k].err);
    end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        seq[0] = 8'($urandom_range(0, 8'h7F));
        seq_len = 1;
      end else if (pick < 92) begin
        if (pick < 52) begin
          seq_len = 2;
          seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
        end else if (pick < 68) begin
          seq_len = 3;
          seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
        end else begin
          seq_len = 4;
          seq[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8'hF5, 8'hF7))
                                                : 8'($urandom_range(8'hF0, 8'hF4));
        end
        for (k = 1; k < seq_len; k++) begin
          seq[k] = 8'h80 | 8'($urandom_range(0, 63));
        end
        if ($urandom_range(0, 9) == 0) begin
          seq_len = $urandom_range(1, seq_len - 1);
        end
      end else begin
        seq[0] = 8'($urandom_range(0, 255));
        seq_len = 1;
      end
      for (k = 0; k < seq_len; k++) begin
        send_byte(seq[k], ROW_PREDICT, 16'h0000, 1'b0);
      end
      sent = sent + seq_len;
    end
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // The receiver changes its stall pattern every so often and twice holds off for a long
  // stretch, so that the result queue fills and the input stalls.
  always @(posedge clk) begin : receiver
    int          rx_cycle;
    int          hold_left;
    ready_mode_t mode;
    rx_cycle = rx_cycle + 1;
    if (rx_cycle == 400 || rx_cycle == 1500) hold_left = 150;
    if (rx_cycle % 120 == 0) mode = ready_mode_t'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_MOSTLY: out_ready <= ($urandom_range(0, 4) != 0);
        READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
        default:      out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: result transfer with none expected: unit %h error %b last %b",
                 $time, code_unit, is_error, last_of_run);
        fail_count = fail_count + 1;
      end else begin
        want = pending_units.pop_front();
        if (code_unit !== want.code_unit) begin
          $display("%0t: code_unit expected %h, got %h", $time, want.code_unit, code_unit);
          fail_count = fail_count + 1;
        end
        if (is_error !== want.is_error) begin
          $display("%0t: is_error expected %b, got %b", $time, want.is_error, is_error);
          fail_count = fail_count + 1;
        end
        if (last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run,
                   last_of_run);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
